FILE: rtl/mtd_pkg.sv
package mtd_pkg;

  localparam int CharWidth  = 8;
  localparam int MaxResults = 3;
  localparam int B64Width   = 18;

  localparam logic [CharWidth-1:0] CharEquals  = 8'h3d;
  localparam logic [CharWidth-1:0] CharSpace   = 8'h20;
  localparam logic [CharWidth-1:0] CharTab     = 8'h09;
  localparam logic [CharWidth-1:0] CharCr      = 8'h0d;
  localparam logic [CharWidth-1:0] CharNewline = 8'h0a;

  typedef enum logic [1:0] {
    ENC_PLAIN  = 2'd0,
    ENC_BASE64 = 2'd1,
    ENC_QP     = 2'd2,
    ENC_RSVD   = 2'd3
  } enc_t;

  typedef enum logic [1:0] {
    QP_IDLE = 2'd0,
    QP_EQ   = 2'd1,
    QP_HIGH = 2'd2,
    QP_DROP = 2'd3
  } qp_phase_t;

  typedef struct packed {
    logic [CharWidth-1:0] char_in;
    logic                 line_end;
    logic                 part_start;
  } item_t;

  // Results of one item: count of valid bytes, bytes in emit order, error flag
  typedef struct packed {
    logic [1:0]                           count;
    logic [MaxResults-1:0][CharWidth-1:0] bytes;
    logic                                 err;
  } group_t;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // {valid, value}
  function automatic logic [6:0] b64_decode(input logic [CharWidth-1:0] c);
    logic [CharWidth-1:0] d;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5a) begin
      d = c - 8'h41;
      return {1'b1, d[5:0]};
    end
    if (c >= 8'h61 && c <= 8'h7a) begin
      d = c - 8'h47;
      return {1'b1, d[5:0]};
    end
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'h04;
      return {1'b1, d[5:0]};
    end
    if (c == 8'h2b) return {1'b1, 6'd62};
    if (c == 8'h2f) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

endpackage

FILE: rtl/mime_transfer_decoder_top.sv
// Path: an accepted item sits in the input register; once the result register is free,
// its results are loaded there and show on m_* one byte at a time, first byte first.
// Throughput: one item per cycle while the receiver is ready and each item yields at most
// one byte; an item with up to three results holds the result register until its last
// byte is taken, so a run is set by the output serialiser. Synchronous active-high rst
// clears all decoder state and the mode.
module mime_transfer_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: transfer encoding (0 plain, 1 base64, 2 quoted-printable)
  input  logic                          cfg_wen,
  input  logic [1:0]                    cfg_wdata,
  // input items
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mtd_pkg::CharWidth-1:0] s_tdata,  // [7:0] char_in
  input  logic                          s_tlast,  // line_end
  input  logic                          s_tuser,  // part_start
  // result items
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mtd_pkg::CharWidth-1:0] m_tdata,  // [7:0] byte_out
  output logic                          m_tlast,  // last_of_run
  output logic                          m_tuser   // decode_error
);
  import mtd_pkg::*;

  enc_t   encoding;
  item_t  item;
  logic   in_valid;
  logic   free;
  logic   advance;
  logic   load;
  group_t grp;

  // Mode register; the user must write it only while the decoder is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      encoding <= ENC_PLAIN;
    end else if (cfg_wen) begin
      encoding <= enc_t'(cfg_wdata);
    end
  end

  // Advance the held item into the decoder state once the result register can take
  // its results; accept a new item in the same cycle.
  assign advance  = in_valid && free;
  assign s_tready = !in_valid || advance;
  assign load     = advance && (grp.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload of the input register, no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.char_in    <= s_tdata;
      item.line_end   <= s_tlast;
      item.part_start <= s_tuser;
    end
  end

  // Decode one item into up to three bytes and update base64/QP state.
  mtd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item     (item),
    .encoding (encoding),
    .grp      (grp)
  );

  // Hold the result group and hand out one byte a cycle while m_tready is high.
  mtd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .grp_in   (grp),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`ifndef NO_ASSERTIONS
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("held item lost while stalled");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted item not in input register");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && !load |=> !m_tvalid)
    else $error("result register not empty after last byte");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("results loaded over a pending group");
`endif

endmodule

FILE: rtl/mtd_decode.sv
module mtd_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  mtd_pkg::item_t item,
  input  mtd_pkg::enc_t  encoding,
  output mtd_pkg::group_t grp
);
  import mtd_pkg::*;

  qp_phase_t             qp_phase, qp_phase_next;
  logic [3:0]            qp_high_nibble, qp_high_nibble_next;
  logic [B64Width-1:0]   b64_bits, b64_bits_next;
  logic [1:0]            b64_count, b64_count_next;
  logic                  pad_seen, pad_seen_next;
  logic                  err_seen, err_seen_next;

  qp_phase_t             ph;
  logic [3:0]            hi;
  logic [B64Width-1:0]   bits;
  logic [1:0]            cnt;
  logic                  pad;
  logic                  err;
  logic [4:0]            hx;
  logic [6:0]            bv;
  logic [23:0]           word;
  logic                  is_ws;
  logic                  newline;

  always_comb begin
    // part start clears the state seen by this item
    ph   = item.part_start ? QP_IDLE : qp_phase;
    hi   = item.part_start ? 4'd0 : qp_high_nibble;
    bits = item.part_start ? '0 : b64_bits;
    cnt  = item.part_start ? 2'd0 : b64_count;
    pad  = item.part_start ? 1'b0 : pad_seen;
    err  = item.part_start ? 1'b0 : err_seen;

    hx    = hex_decode(item.char_in);
    bv    = b64_decode(item.char_in);
    word  = {bits, bv[5:0]};
    is_ws = (item.char_in == CharSpace) ||
            (item.char_in >= CharTab && item.char_in <= CharCr);
    newline = item.line_end;

    qp_phase_next       = ph;
    qp_high_nibble_next = hi;
    b64_bits_next       = bits;
    b64_count_next      = cnt;
    pad_seen_next       = pad;
    err_seen_next       = err;

    grp.count = 2'd0;
    grp.bytes = '0;

    case (encoding)
      ENC_BASE64: begin
        if (pad || is_ws) begin
          // skip
        end else if (item.char_in == CharEquals) begin
          case (cnt)
            2'd1: err_seen_next = 1'b1;
            2'd2: begin
              grp.count    = 2'd1;
              grp.bytes[0] = bits[11:4];
            end
            2'd3: begin
              grp.count    = 2'd2;
              grp.bytes[0] = bits[17:10];
              grp.bytes[1] = bits[9:2];
            end
            default: ;
          endcase
          b64_bits_next  = '0;
          b64_count_next = 2'd0;
          pad_seen_next  = 1'b1;
        end else if (!bv[6]) begin
          err_seen_next = 1'b1;
        end else if (cnt == 2'd3) begin
          grp.count      = 2'd3;
          grp.bytes[0]   = word[23:16];
          grp.bytes[1]   = word[15:8];
          grp.bytes[2]   = word[7:0];
          b64_bits_next  = '0;
          b64_count_next = 2'd0;
        end else begin
          b64_bits_next  = {bits[11:0], bv[5:0]};
          b64_count_next = cnt + 2'd1;
        end
      end
      ENC_QP: begin
        case (ph)
          QP_IDLE: begin
            if (item.char_in == CharEquals) begin
              if (item.line_end) newline = 1'b0;
              else qp_phase_next = QP_EQ;
            end else begin
              grp.count    = 2'd1;
              grp.bytes[0] = item.char_in;
            end
          end
          QP_EQ: begin
            if (!hx[4]) begin
              err_seen_next = 1'b1;
              qp_phase_next = QP_DROP;
            end else if (item.line_end) begin
              grp.count    = 2'd1;
              grp.bytes[0] = {4'd0, hx[3:0]};
            end else begin
              qp_high_nibble_next = hx[3:0];
              qp_phase_next       = QP_HIGH;
            end
          end
          QP_HIGH: begin
            grp.count = 2'd1;
            if (!hx[4]) begin
              err_seen_next = 1'b1;
              grp.bytes[0]  = {4'd0, hi};
            end else begin
              grp.bytes[0]  = {hi, hx[3:0]};
            end
            qp_phase_next = QP_IDLE;
          end
          default: qp_phase_next = QP_IDLE;
        endcase
        if (item.line_end) qp_phase_next = QP_IDLE;
        if (newline) begin
          grp.bytes[grp.count] = CharNewline;
          grp.count            = grp.count + 2'd1;
        end
      end
      default: begin
        // plain, and the unused code that behaves as plain
        grp.bytes[0] = item.char_in;
        grp.bytes[1] = CharNewline;
        grp.count    = item.line_end ? 2'd2 : 2'd1;
      end
    endcase

    grp.err = err_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qp_phase       <= QP_IDLE;
      qp_high_nibble <= 4'd0;
      b64_bits       <= '0;
      b64_count      <= 2'd0;
      pad_seen       <= 1'b0;
      err_seen       <= 1'b0;
    end else if (step) begin
      qp_phase       <= qp_phase_next;
      qp_high_nibble <= qp_high_nibble_next;
      b64_bits       <= b64_bits_next;
      b64_count      <= b64_count_next;
      pad_seen       <= pad_seen_next;
      err_seen       <= err_seen_next;
    end
  end

endmodule

FILE: rtl/mtd_out.sv
module mtd_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  mtd_pkg::group_t                 grp_in,
  output logic                            free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mtd_pkg::CharWidth-1:0]   m_tdata,
  output logic                            m_tlast,
  output logic                            m_tuser
);
  import mtd_pkg::*;

  group_t     grp;
  logic [1:0] idx;
  logic       take;

  assign m_tvalid = (grp.count != 2'd0);
  assign m_tdata  = grp.bytes[idx];
  assign m_tlast  = (idx == grp.count - 2'd1);
  assign m_tuser  = grp.err;
  assign take     = m_tvalid && m_tready;
  assign free     = !m_tvalid || (take && m_tlast);

  // Bytes and error flag need no reset; only the count marks the group as valid
  always_ff @(posedge clk) begin
    if (rst) begin
      grp.count <= 2'd0;
      idx       <= 2'd0;
    end else if (load) begin
      grp       <= grp_in;
      idx       <= 2'd0;
    end else if (take) begin
      if (m_tlast) grp.count <= 2'd0;
      idx <= m_tlast ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

FILE: tb/mime_transfer_decoder_top_test.sv
`timescale 1ns / 100ps

module mime_transfer_decoder_top_test;
  import mtd_pkg::*;

  // Marks a directed row whose results come from the decoder model below
  localparam int ByPredictor = -1;
  // Long receiver hold-off, long enough to back the block up into its input
  localparam int LongHold = 80;
  // Cycles to let an item that yields no byte clear the pipeline
  localparam int SettleCycles = 4;
  localparam int RandomItems = 100;
  localparam int QuietFrom = 76;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [1:0]           cfg_wdata = ENC_PLAIN;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [CharWidth-1:0] s_tdata = '0;  // [7:0] char_in
  logic                 s_tlast = 1'b0;  // line_end
  logic                 s_tuser = 1'b0;  // part_start
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [CharWidth-1:0] m_tdata;  // [7:0] byte_out
  logic                 m_tlast;  // last_of_run
  logic                 m_tuser;  // decode_error

  mime_transfer_decoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One decoded byte as it should leave the block
  typedef struct packed {
    logic [CharWidth-1:0] data;
    logic                 last;
    logic                 err;
  } out_byte_t;

  out_byte_t awaited_bytes[$];
  int        mismatches = 0;

  // ---------------------------------------------------------------------------
  // Decoder model: its own copy of the mode and of the per-part state
  // ---------------------------------------------------------------------------
  enc_t            cur_enc;
  qp_phase_t       qp_state;
  logic [3:0]      qp_nib;
  logic [17:0]     b64_acc;
  logic [1:0]      b64_fill;
  logic            b64_done;
  logic            err_flag;

  task automatic clear_part();
    qp_state = QP_IDLE;
    qp_nib   = '0;
    b64_acc  = '0;
    b64_fill = '0;
    b64_done = 1'b0;
    err_flag = 1'b0;
  endtask

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic int b64_val(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return int'(c - "a") + 26;
    if (c >= "0" && c <= "9") return int'(c - "0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  // Advance the model by one item; give back the bytes it yields, in order
  task automatic decode_item(input logic [7:0] c, input logic eol, input logic ps,
                             output int n, output logic [0:2][7:0] b);
    int          h;
    int          v;
    logic        nl;
    logic [23:0] w;
    n = 0;
    b = '0;
    if (ps) clear_part();
    case (cur_enc)
      ENC_BASE64: begin
        // whitespace and everything after the pad are dropped silently
        if (!b64_done && !(c == CharSpace || (c >= CharTab && c <= CharCr))) begin
          if (c == CharEquals) begin
            if (b64_fill == 2'd1) begin
              err_flag = 1'b1;
            end else if (b64_fill == 2'd2) begin
              b[0] = b64_acc[11:4];
              n = 1;
            end else if (b64_fill == 2'd3) begin
              b[0] = b64_acc[17:10];
              b[1] = b64_acc[9:2];
              n = 2;
            end
            b64_acc  = '0;
            b64_fill = '0;
            b64_done = 1'b1;
          end else begin
            v = b64_val(c);
            if (v < 0) begin
              err_flag = 1'b1;
            end else if (b64_fill == 2'd3) begin
              w = {b64_acc, v[5:0]};
              b[0] = w[23:16];
              b[1] = w[15:8];
              b[2] = w[7:0];
              n = 3;
              b64_acc  = '0;
              b64_fill = '0;
            end else begin
              b64_acc  = {b64_acc[11:0], v[5:0]};
              b64_fill = b64_fill + 2'd1;
            end
          end
        end
      end
      ENC_QP: begin
        h  = hex_val(c);
        nl = eol;
        case (qp_state)
          QP_IDLE: begin
            if (c == CharEquals) begin
              // a trailing '=' is a soft break: hold back the newline
              if (eol) nl = 1'b0;
              else qp_state = QP_EQ;
            end else begin
              b[n] = c;
              n = n + 1;
            end
          end
          QP_EQ: begin
            if (h < 0) begin
              err_flag = 1'b1;
              qp_state = QP_DROP;
            end else if (eol) begin
              b[n] = {4'h0, h[3:0]};
              n = n + 1;
            end else begin
              qp_nib   = h[3:0];
              qp_state = QP_HIGH;
            end
          end
          QP_HIGH: begin
            if (h < 0) begin
              err_flag = 1'b1;
              b[n] = {4'h0, qp_nib};
            end else begin
              b[n] = {qp_nib, h[3:0]};
            end
            n = n + 1;
            qp_state = QP_IDLE;
          end
          default: qp_state = QP_IDLE;
        endcase
        if (eol) qp_state = QP_IDLE;
        if (nl) begin
          b[n] = CharNewline;
          n = n + 1;
        end
      end
      default: begin
        // plain, and the spare code behaves as plain
        b[0] = c;
        n = 1;
        if (eol) begin
          b[1] = CharNewline;
          n = 2;
        end
      end
    endcase
  endtask

  task automatic queue_bytes(input int n, input logic [0:2][7:0] b, input logic err);
    out_byte_t o;
    for (int i = 0; i < n; i++) begin
      o.data = b[i];
      o.last = (i == n - 1);
      o.err  = err;
      awaited_bytes.push_back(o);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  logic src_idle_on  = 1'b1;
  logic sink_idle_on = 1'b1;
  logic hold_req     = 1'b0;

  // Offer one item, with an occasional idle burst first; return at the edge
  // that accepts it, leaving tvalid high for a following item.
  task automatic offer_item(input logic [7:0] ch, input logic eol, input logic ps);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eol;
    s_tuser  <= ps;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait for every outstanding byte
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
  endtask

  // Change mode only once the block has nothing in flight
  task automatic write_encoding(input enc_t e);
    drain_results();
    repeat (SettleCycles) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_wen <= 1'b0;
    cur_enc = e;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int   hold_left  = 0;
  int   stall_left = 0;
  logic hold_taken = 1'b0;

  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LongHold;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking: each accepted byte against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  out_byte_t head;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 0, m_tdata);
      end else begin
        head = awaited_bytes.pop_front();
        if (m_tdata !== head.data) report_mismatch("byte_out", head.data, m_tdata);
        if (m_tlast !== head.last) report_mismatch("last_of_run", head.last, m_tlast);
        if (m_tuser !== head.err) report_mismatch("decode_error", head.err, m_tuser);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed stimulus; rows with typed bytes carry results readable at a glance
  // ---------------------------------------------------------------------------
  typedef struct {
    enc_t            enc;
    logic [7:0]      ch;
    logic            eol;
    logic            ps;
    int              n_typed;
    logic [0:2][7:0] bytes;
    logic            err;
  } dir_row_t;

  dir_row_t directed_rows [26] = '{
    // plain straight after reset: NUL passes, top byte plus newline
    '{ENC_PLAIN,  8'h00, 1'b0, 1'b1, 1, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_PLAIN,  8'hff, 1'b1, 1'b0, 2, '{8'hff, 8'h0a, 8'h00}, 1'b0},
    // base64: a full group ending at a line end gives "Man"
    '{ENC_BASE64, "T",   1'b0, 1'b1, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_BASE64, "W",   1'b0, 1'b0, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_BASE64, "F",   1'b0, 1'b0, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_BASE64, "u",   1'b1, 1'b0, 3, '{8'h4d, 8'h61, 8'h6e}, 1'b0},
    // whitespace skipped, an invalid symbol dropped with the error raised
    '{ENC_BASE64, 8'h0d, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_BASE64, "*",   1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 1'b1},
    // pad after two symbols flushes one byte, error still sticky
    '{ENC_BASE64, "Q",   1'b0, 1'b0, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_BASE64, "Q",   1'b0, 1'b0, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_BASE64, "=",   1'b0, 1'b0, 1, '{8'h41, 8'h00, 8'h00}, 1'b1},
    // new part, pad after a lone symbol: nothing out, error raised
    '{ENC_BASE64, "A",   1'b0, 1'b1, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_BASE64, "=",   1'b1, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 1'b1},
    // quoted-printable: full escape, then a soft break
    '{ENC_QP,     "=",   1'b0, 1'b1, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_QP,     "4",   1'b0, 1'b0, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_QP,     "1",   1'b1, 1'b0, 2, '{8'h41, 8'h0a, 8'h00}, 1'b0},
    '{ENC_QP,     "=",   1'b1, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 1'b0},
    // single hex digit at line end gives its value, then the newline
    '{ENC_QP,     "=",   1'b0, 1'b0, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_QP,     "a",   1'b1, 1'b0, 2, '{8'h0a, 8'h0a, 8'h00}, 1'b0},
    // bad first escape char: error, next byte of the line swallowed
    '{ENC_QP,     "=",   1'b0, 1'b0, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_QP,     "G",   1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}, 1'b1},
    '{ENC_QP,     "Z",   1'b1, 1'b0, 1, '{8'h0a, 8'h00, 8'h00}, 1'b1},
    // bad second escape char: first digit's value out, error raised
    '{ENC_QP,     "=",   1'b0, 1'b1, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_QP,     "F",   1'b0, 1'b0, ByPredictor, '{8'h00, 8'h00, 8'h00}, 1'b0},
    '{ENC_QP,     "!",   1'b1, 1'b0, 2, '{8'h0f, 8'h0a, 8'h00}, 1'b1},
    // spare encoding code decodes as plain
    '{ENC_RSVD,   "q",   1'b1, 1'b1, 2, '{8'h71, 8'h0a, 8'h00}, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Random lines, shaped per mode so that decoding gets past its first states
  // ---------------------------------------------------------------------------
  logic [7:0] line_chars[$];

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] b64_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return (r == 62) ? 8'("+") : 8'("/");
  endfunction

  task automatic build_line(input enc_t e);
    int len;
    int r;
    line_chars.delete();
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      case (e)
        ENC_BASE64: begin
          if (r < 80) line_chars.push_back(b64_char());
          else if (r < 86) line_chars.push_back((r < 83) ? CharSpace : 8'($urandom_range(9, 13)));
          else if (r < 90) line_chars.push_back(CharEquals);
          else line_chars.push_back(8'($urandom_range(0, 255)));
        end
        ENC_QP: begin
          if (r < 55) begin
            line_chars.push_back(8'($urandom_range(32, 126)));
          end else if (r < 75) begin
            line_chars.push_back(CharEquals);
            line_chars.push_back(hex_char());
            line_chars.push_back(hex_char());
          end else if (r < 82) begin
            line_chars.push_back(CharEquals);
            line_chars.push_back(hex_char());
          end else if (r < 88) begin
            line_chars.push_back(CharEquals);
            line_chars.push_back(8'($urandom_range(0, 255)));
          end else begin
            line_chars.push_back(8'($urandom_range(0, 255)));
          end
        end
        default: line_chars.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    // now and then end a quoted-printable line on a soft break
    if (e == ENC_QP && $urandom_range(0, 4) == 0) line_chars.push_back(CharEquals);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  enc_t phase_order[4] = '{ENC_BASE64, ENC_QP, ENC_RSVD, ENC_PLAIN};

  initial begin
    int              n;
    logic [0:2][7:0] b;
    int              counted;
    int              phase;
    int              lines;
    enc_t            e;
    logic            ps;
    logic            eol;

    cur_enc = ENC_PLAIN;
    clear_part();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: change mode between rows only once the block is idle
    foreach (directed_rows[i]) begin
      if (directed_rows[i].enc != cur_enc) write_encoding(directed_rows[i].enc);
      offer_item(directed_rows[i].ch, directed_rows[i].eol, directed_rows[i].ps);
      decode_item(directed_rows[i].ch, directed_rows[i].eol, directed_rows[i].ps, n, b);
      if (directed_rows[i].n_typed == ByPredictor) begin
        queue_bytes(n, b, err_flag);
      end else begin
        queue_bytes(directed_rows[i].n_typed, directed_rows[i].bytes, directed_rows[i].err);
      end
    end

    // Random phases: every mode in turn, then random modes until enough items
    counted = 0;
    phase   = 0;
    while (counted < RandomItems) begin
      e = (phase < 4) ? phase_order[phase] : enc_t'($urandom_range(0, 3));
      write_encoding(e);
      // back the block up once with a long receiver hold-off
      if (phase == 1) hold_req <= 1'b1;
      lines = $urandom_range(3, 6);
      for (int l = 0; l < lines; l++) begin
        // pause the sender once until every byte has come back
        if (phase == 2 && l == 1) drain_results();
        build_line(e);
        ps = (l == 0) || ($urandom_range(0, 4) == 0);
        foreach (line_chars[k]) begin
          eol = (k == line_chars.size() - 1);
          // bytes after a base64 pad are ignored; leave them out of the count
          if (!(cur_enc == ENC_BASE64 && b64_done && !(ps && k == 0))) counted++;
          // run the tail of the stimulus at full rate on both sides
          if (counted >= QuietFrom) begin
            src_idle_on  = 1'b0;
            sink_idle_on = 1'b0;
          end
          offer_item(line_chars[k], eol, ps && k == 0);
          decode_item(line_chars[k], eol, ps && k == 0, n, b);
          queue_bytes(n, b, err_flag);
        end
      end
      phase++;
    end

    drain_results();
    repeat (SettleCycles * 2) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS mime_transfer_decoder_top");
    end else begin
      $display("FAIL mime_transfer_decoder_top");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("FAIL mime_transfer_decoder_top");
    $finish;
  end

endmodule
